FILE: sv/wsd_pkg.sv
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Widths and header codes shared by the deframer design.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wsd_pkg;

    localparam int BYTE_W   = 8;
    localparam int OPCODE_W = 4;
    localparam int LEN_W    = 64;
    localparam int KEY_W    = 32;
    localparam int CNT_W    = 3;
    localparam int KIDX_W   = 2;

    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    localparam logic [CNT_W-1:0] EXT16_LAST_CNT = 3'd1;
    localparam logic [CNT_W-1:0] EXT64_LAST_CNT = 3'd7;
    localparam logic [CNT_W-1:0] KEY_LAST_CNT   = 3'd3;

endpackage

FILE: sv/websocket_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses a received byte stream into WebSocket frames and emits the
// unmasked payload bytes, tagged with the frame opcode.
//
// Usage:
//   s_valid / s_ready / s_rx_byte carry the received stream, one byte a beat.
//   m_valid / m_ready carry results: m_payload_byte, m_frame_opcode,
//   m_last_in_frame, m_empty_frame. Header bytes (two base bytes, a 16-bit
//   or 64-bit extended length, an optional 4-byte key) produce no beat;
//   each payload byte produces one beat; a zero-length frame produces one
//   beat with m_empty_frame and m_last_in_frame set and a zero byte.
//   Results are registered and appear in the cycle after the input beat is taken.
//   Throughput: one input beat per cycle unless the output stalls; the parse
//   state and the 64-bit length counter update with each byte taken.
//   Stall: the result register holds while m_ready is low; s_ready then
//   drops, and rises in the same cycle the pending result is taken.
//   Reset: aresetn low at a clock edge returns the parser to expect the
//   first header byte and empties the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module websocket_frame_deframer_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [wsd_pkg::BYTE_W-1:0]   s_rx_byte,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [wsd_pkg::BYTE_W-1:0]   m_payload_byte,
    output logic [wsd_pkg::OPCODE_W-1:0] m_frame_opcode,
    output logic                         m_last_in_frame,
    output logic                         m_empty_frame
);
    import wsd_pkg::*;

    typedef enum logic [2:0] {
        PH_HDR0  = 3'd0,
        PH_HDR1  = 3'd1,
        PH_EXT16 = 3'd2,
        PH_EXT64 = 3'd3,
        PH_KEY   = 3'd4,
        PH_DATA  = 3'd5
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic [OPCODE_W-1:0]   opcode_reg, opcode_next;
    logic                  masked_reg, masked_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [LEN_W-1:0]      rem_reg, rem_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [KIDX_W-1:0]     kidx_reg, kidx_next;

    logic                  m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]     byte_reg, byte_next;
    logic [OPCODE_W-1:0]   op_out_reg, op_out_next;
    logic                  last_reg, last_next;
    logic                  empty_reg, empty_next;

    logic                  accept;
    logic                  emit;
    logic [BYTE_W-1:0]     key_byte;
    logic [6:0]            len_code;
    logic [LEN_W-1:0]      rem_hdr;
    logic [LEN_W-1:0]      rem_ext16;
    logic [LEN_W-1:0]      rem_ext64;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign len_code  = s_rx_byte[6:0];
    assign rem_hdr   = {{(LEN_W-7){1'b0}}, len_code};
    assign rem_ext16 = {{(LEN_W-16){1'b0}}, rem_reg[7:0], s_rx_byte};
    assign rem_ext64 = {rem_reg[LEN_W-BYTE_W-1:0], s_rx_byte};

    always_comb begin
        case (kidx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
        if (!masked_reg) begin
            key_byte = '0;
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        opcode_next = opcode_reg;
        masked_next = masked_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        key_next    = key_reg;
        kidx_next   = kidx_reg;
        emit        = 1'b0;
        byte_next   = '0;
        last_next   = 1'b0;
        empty_next  = 1'b0;

        case (phase_reg)
            PH_HDR1: begin
                masked_next = s_rx_byte[7];
                cnt_next    = '0;
                rem_next    = '0;
                if (len_code == LEN_CODE_16) begin
                    phase_next = PH_EXT16;
                end else if (len_code == LEN_CODE_64) begin
                    phase_next = PH_EXT64;
                end else begin
                    rem_next  = rem_hdr;
                    kidx_next = '0;
                    key_next  = '0;
                    if (s_rx_byte[7]) begin
                        phase_next = PH_KEY;
                    end else if (len_code == 7'd0) begin
                        phase_next = PH_HDR0;
                        emit       = 1'b1;
                        last_next  = 1'b1;
                        empty_next = 1'b1;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_EXT16, PH_EXT64: begin
                rem_next = (phase_reg == PH_EXT16) ? rem_ext16 : rem_ext64;
                if ((phase_reg == PH_EXT16 && cnt_reg >= EXT16_LAST_CNT) ||
                    (phase_reg == PH_EXT64 && cnt_reg >= EXT64_LAST_CNT)) begin
                    cnt_next  = '0;
                    kidx_next = '0;
                    key_next  = '0;
                    if (masked_reg) begin
                        phase_next = PH_KEY;
                    end else if (rem_next == '0) begin
                        phase_next = PH_HDR0;
                        emit       = 1'b1;
                        last_next  = 1'b1;
                        empty_next = 1'b1;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end else begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            PH_KEY: begin
                key_next = {key_reg[KEY_W-BYTE_W-1:0], s_rx_byte};
                if (cnt_reg >= KEY_LAST_CNT) begin
                    cnt_next  = '0;
                    kidx_next = '0;
                    if (rem_reg == '0) begin
                        phase_next = PH_HDR0;
                        emit       = 1'b1;
                        last_next  = 1'b1;
                        empty_next = 1'b1;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end else begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            PH_DATA: begin
                kidx_next = kidx_reg + 2'd1;
                rem_next  = rem_reg - 64'd1;
                emit      = 1'b1;
                byte_next = s_rx_byte ^ key_byte;
                last_next = (rem_reg == 64'd1);
                if (rem_reg == 64'd1) begin
                    phase_next = PH_HDR0;
                end
            end
            default: begin
                opcode_next = s_rx_byte[OPCODE_W-1:0];
                phase_next  = PH_HDR1;
                cnt_next    = '0;
            end
        endcase
    end

    always_comb begin
        op_out_next  = opcode_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (accept) begin
            m_valid_next = emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HDR0;
            opcode_reg  <= '0;
            masked_reg  <= 1'b0;
            cnt_reg     <= '0;
            rem_reg     <= '0;
            key_reg     <= '0;
            kidx_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                phase_reg  <= phase_next;
                opcode_reg <= opcode_next;
                masked_reg <= masked_next;
                cnt_reg    <= cnt_next;
                rem_reg    <= rem_next;
                key_reg    <= key_next;
                kidx_reg   <= kidx_next;
            end
        end
    end

    // hold the result until taken
    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            byte_reg   <= byte_next;
            op_out_reg <= op_out_next;
            last_reg   <= last_next;
            empty_reg  <= empty_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_payload_byte  = byte_reg;
    assign m_frame_opcode  = op_out_reg;
    assign m_last_in_frame = last_reg;
    assign m_empty_frame   = empty_reg;

    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && empty_reg |-> last_reg && byte_reg == '0)
        else $error("empty frame result without last flag or with nonzero byte");

    a_data_len_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DATA |-> rem_reg != '0)
        else $error("payload phase with zero remaining length");

    a_hdr0_to_hdr1: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && phase_reg == PH_HDR0 |=> phase_reg == PH_HDR1 && !m_valid_reg)
        else $error("first header byte did not advance to second header byte");

    a_last_to_hdr0: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && phase_reg == PH_DATA && rem_reg == 64'd1
        |=> phase_reg == PH_HDR0 && m_valid_reg && last_reg)
        else $error("final payload byte did not close the frame");

    a_key_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_KEY |-> cnt_reg <= KEY_LAST_CNT)
        else $error("key byte count out of range");

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Feeds a table of hand-built frames and then random frames into the
// deframer, with random idling on both channels and one long output stall.
// The table or, for random frames, a local parser predicts each payload
// beat; each result beat is compared field by field, in order, with it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import wsd_pkg::*;

    localparam int NUM_DIRECTED  = 23;
    localparam int RANDOM_BEATS  = 760;
    localparam int ENDLESS_BYTES = 40;
    localparam int HOLD_AT_BEAT  = 500;
    localparam int HOLD_CYCLES   = 80;
    localparam int STALL_LIMIT   = 5000;
    localparam int DRAIN_CYCLES  = 10;
    localparam int IDLE_PCT      = 26;

    typedef enum logic [2:0] {
        PS_BASE0, PS_BASE1, PS_EXT16, PS_EXT64, PS_KEY, PS_PAYLOAD
    } parse_e;

    typedef struct packed {
        logic [BYTE_W-1:0]   data;
        logic [OPCODE_W-1:0] opcode;
        logic                last;
        logic                empty;
    } payload_beat_t;

    typedef struct packed {
        logic [BYTE_W-1:0] rx;
        logic              typed;
        payload_beat_t     want;
    } dir_row_t;

    localparam payload_beat_t NO_BEAT = '0;

    dir_row_t directed_rows [NUM_DIRECTED] = '{
        '{8'h80, 1'b0, NO_BEAT},
        '{8'h00, 1'b1, '{8'h00, 4'h0, 1'b1, 1'b1}},
        '{8'h7F, 1'b0, NO_BEAT},
        '{8'h7E, 1'b0, NO_BEAT},
        '{8'h00, 1'b0, NO_BEAT},
        '{8'h01, 1'b0, NO_BEAT},
        '{8'hA5, 1'b1, '{8'hA5, 4'hF, 1'b1, 1'b0}},
        '{8'h09, 1'b0, NO_BEAT},
        '{8'hFF, 1'b0, NO_BEAT},
        '{8'h00, 1'b0, NO_BEAT},
        '{8'h00, 1'b0, NO_BEAT},
        '{8'h00, 1'b0, NO_BEAT},
        '{8'h00, 1'b0, NO_BEAT},
        '{8'h00, 1'b0, NO_BEAT},
        '{8'h00, 1'b0, NO_BEAT},
        '{8'h00, 1'b0, NO_BEAT},
        '{8'h02, 1'b0, NO_BEAT},
        '{8'hFF, 1'b0, NO_BEAT},
        '{8'h00, 1'b0, NO_BEAT},
        '{8'hAA, 1'b0, NO_BEAT},
        '{8'h55, 1'b0, NO_BEAT},
        '{8'h0F, 1'b1, '{8'hF0, 4'h9, 1'b0, 1'b0}},
        '{8'hF0, 1'b1, '{8'hF0, 4'h9, 1'b1, 1'b0}}
    };

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [BYTE_W-1:0]   s_rx_byte;
    logic                m_valid;
    logic                m_ready;
    logic [BYTE_W-1:0]   m_payload_byte;
    logic [OPCODE_W-1:0] m_frame_opcode;
    logic                m_last_in_frame;
    logic                m_empty_frame;

    logic                s_typed;
    payload_beat_t       s_want;

    parse_e              phase;
    logic [OPCODE_W-1:0] cur_opcode;
    logic                masked;
    logic [CNT_W-1:0]    hdr_cnt;
    logic [LEN_W-1:0]    bytes_left;
    logic [KEY_W-1:0]    key;
    logic [KIDX_W-1:0]   key_sel;

    payload_beat_t       unmasked_q [$];
    logic [BYTE_W-1:0]   tx_bytes [$];
    int                  beats_in = 0;
    int                  beats_sent = 0;
    int                  mismatch_count = 0;
    int                  quiet_cycles = 0;

    websocket_frame_deframer_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_payload_byte  (m_payload_byte),
        .m_frame_opcode  (m_frame_opcode),
        .m_last_in_frame (m_last_in_frame),
        .m_empty_frame   (m_empty_frame)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    function automatic bit open_payload(output payload_beat_t res);
        res     = '0;
        hdr_cnt = '0;
        key_sel = '0;
        if (bytes_left == '0) begin
            phase = PS_BASE0;
            res   = {BYTE_W'(0), cur_opcode, 1'b1, 1'b1};
            return 1'b1;
        end
        phase = PS_PAYLOAD;
        return 1'b0;
    endfunction

    function automatic bit close_length(output payload_beat_t res);
        res = '0;
        key = '0;
        if (masked) begin
            hdr_cnt = '0;
            key_sel = '0;
            phase   = PS_KEY;
            return 1'b0;
        end
        return open_payload(res);
    endfunction

    function automatic bit deframe_byte(input logic [BYTE_W-1:0] b,
                                        output payload_beat_t res);
        logic [BYTE_W-1:0] k;
        res = '0;
        case (phase)
            PS_BASE1: begin
                masked     = b[7];
                bytes_left = '0;
                hdr_cnt    = '0;
                if (b[6:0] == LEN_CODE_16) begin
                    phase = PS_EXT16;
                end else if (b[6:0] == LEN_CODE_64) begin
                    phase = PS_EXT64;
                end else begin
                    bytes_left = LEN_W'(b[6:0]);
                    return close_length(res);
                end
            end
            PS_EXT16: begin
                bytes_left = {48'h0, bytes_left[7:0], b};
                if (hdr_cnt >= EXT16_LAST_CNT) return close_length(res);
                hdr_cnt++;
            end
            PS_EXT64: begin
                bytes_left = {bytes_left[LEN_W-9:0], b};
                if (hdr_cnt >= EXT64_LAST_CNT) return close_length(res);
                hdr_cnt++;
            end
            PS_KEY: begin
                key = {key[KEY_W-9:0], b};
                if (hdr_cnt >= KEY_LAST_CNT) return open_payload(res);
                hdr_cnt++;
            end
            PS_PAYLOAD: begin
                k = masked ? key[24 - 8 * key_sel +: 8] : '0;
                key_sel++;
                bytes_left--;
                if (bytes_left == '0) phase = PS_BASE0;
                res = {b ^ k, cur_opcode, bytes_left == '0, 1'b0};
                return 1'b1;
            end
            default: begin
                cur_opcode = b[OPCODE_W-1:0];
                phase      = PS_BASE1;
                hdr_cnt    = '0;
            end
        endcase
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < 100)
            $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : scoreboard
        payload_beat_t predicted;
        payload_beat_t want;
        bit            emitted;
        if (!aresetn) begin
            phase      = PS_BASE0;
            cur_opcode = '0;
            masked     = 1'b0;
            hdr_cnt    = '0;
            bytes_left = '0;
            key        = '0;
            key_sel    = '0;
            unmasked_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                beats_in++;
                emitted = deframe_byte(s_rx_byte, predicted);
                if (s_typed) unmasked_q.push_back(s_want);
                else if (emitted) unmasked_q.push_back(predicted);
            end
            if (m_valid && m_ready) begin
                if (unmasked_q.size() == 0) begin
                    report_mismatch("unexpected beat", 64'(m_payload_byte), 64'(0));
                end else begin
                    want = unmasked_q.pop_front();
                    if (m_payload_byte !== want.data)
                        report_mismatch("payload_byte", 64'(m_payload_byte),
                                        64'(want.data));
                    if (m_frame_opcode !== want.opcode)
                        report_mismatch("frame_opcode", 64'(m_frame_opcode),
                                        64'(want.opcode));
                    if (m_last_in_frame !== want.last)
                        report_mismatch("last_in_frame", 64'(m_last_in_frame),
                                        64'(want.last));
                    if (m_empty_frame !== want.empty)
                        report_mismatch("empty_frame", 64'(m_empty_frame),
                                        64'(want.empty));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic typed,
                             input payload_beat_t want);
        while (!(beats_sent >= 150 && beats_sent < 350)
               && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        s_typed   <= typed;
        s_want    <= want;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
    endtask

    task automatic queue_frame(input bit endless);
        logic [6:0]       code;
        logic [LEN_W-1:0] len;
        logic             mask_on;
        int unsigned      pick;
        int               n_ext;
        int unsigned      n_payload;
        pick    = $urandom_range(99);
        mask_on = 1'($urandom_range(1));
        n_ext   = 0;
        if (endless) begin
            // finish on a frame whose length never runs out
            code = LEN_CODE_64;
            len  = {1'b1, 31'($urandom), 32'($urandom)};
            n_ext = 8;
        end else if (pick < 55) begin
            code = 7'($urandom_range(0, 8));
            len  = LEN_W'(code);
        end else if (pick < 70) begin
            code = 7'($urandom_range(9, 125));
            len  = LEN_W'(code);
        end else if (pick < 85) begin
            code  = LEN_CODE_16;
            n_ext = 2;
            len   = LEN_W'(($urandom_range(7) == 0) ? $urandom_range(130, 290)
                                                     : $urandom_range(0, 12));
        end else begin
            code  = LEN_CODE_64;
            n_ext = 8;
            len   = LEN_W'($urandom_range(0, 12));
        end
        n_payload = endless ? ENDLESS_BYTES : int'(len);
        tx_bytes.push_back(8'($urandom));
        tx_bytes.push_back({mask_on, code});
        for (int i = n_ext - 1; i >= 0; i--) tx_bytes.push_back(len[8 * i +: 8]);
        if (mask_on) repeat (4) tx_bytes.push_back(8'($urandom));
        repeat (n_payload) tx_bytes.push_back(8'($urandom));
    endtask

    initial begin : sink
        int unsigned cycles;
        bit          held;
        cycles  = 0;
        held    = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (!held && beats_in >= HOLD_AT_BEAT) begin
                // hold results back so the input stalls
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= (cycles >= 300 && cycles < 600) || $urandom_range(99) >= IDLE_PCT;
        end
    end

    initial begin : stimulus
        bit endless;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_rx_byte = '0;
        s_typed   = 1'b0;
        s_want    = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (directed_rows[i])
            send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want);
        do begin
            endless = beats_sent >= NUM_DIRECTED + RANDOM_BEATS;
            queue_frame(endless);
            while (tx_bytes.size() != 0) send_byte(tx_bytes.pop_front(), 1'b0, NO_BEAT);
        end while (!endless);
        s_valid <= 1'b0;
        while (unmasked_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
